[hdl/mpr_pkg.sv]
`default_nettype none

package mpr_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int OUT_ADDR_BITS  = 32;
  localparam int CLIP_BITS      = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_STRIDE  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_BASE  = 3'd5;

  localparam logic [CLIP_BITS-1:0] CLIP_MAX = 16'hffff;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  // one masked byte write
  typedef struct packed {
    logic [OUT_ADDR_BITS-1:0] write_address;
    logic [7:0]               write_data;
    logic [7:0]               write_mask;
    logic                     last_write;
  } mpr_word_t;

  // writes produced by one source byte; a second write is always the last one
  typedef struct packed {
    logic       emit0;
    logic       emit1;
    logic [7:0] data0;
    logic [7:0] mask0;
    logic       last0;
    logic [7:0] data1;
    logic [7:0] mask1;
    logic [1:0] addr_inc;
  } mpr_emit_t;

endpackage

`default_nettype wire

[hdl/mpr_ifs.sv]
`default_nettype none

interface mpr_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] span_x;
  logic signed [COORD_BITS-1:0] span_y;
  logic signed [COORD_BITS-1:0] span_width;
  logic [7:0]                   source_byte;

  modport source (output valid, req_type, span_x, span_y, span_width, source_byte,
                  input ready);
  modport sink (input valid, req_type, span_x, span_y, span_width, source_byte,
                output ready);
endinterface

interface mpr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic [7:0]  write_mask;
  logic        last_write;

  modport source (output valid, write_address, write_data, write_mask, last_write,
                  input ready);
  modport sink (input valid, write_address, write_data, write_mask, last_write,
                output ready);
endinterface

`default_nettype wire

[hdl/mpr_span_setup.sv]
`default_nettype none

module mpr_span_setup #(
  parameter int ADDRESS_BITS = 32,
  parameter int COORD_BITS   = 16,
  parameter int EW           = 19,
  parameter int SBL_BITS     = 13
) (
  input  wire logic signed [COORD_BITS-1:0] span_x,
  input  wire logic signed [COORD_BITS-1:0] span_y,
  input  wire logic signed [COORD_BITS-1:0] span_width,
  input  wire logic [15:0]                  clip_left,
  input  wire logic [15:0]                  clip_top,
  input  wire logic [15:0]                  clip_right,
  input  wire logic [15:0]                  clip_bottom,
  input  wire logic [15:0]                  row_stride,
  input  wire logic [31:0]                  frame_base,
  output logic [SBL_BITS-1:0]               bytes_left,
  output logic [EW-1:0]                     skip,
  output logic [EW-1:0]                     pixels,
  output logic [2:0]                        bit_pos,
  output logic [ADDRESS_BITS-1:0]           address
);

  localparam int SUMW = (ADDRESS_BITS > 33) ? ADDRESS_BITS : 33;

  logic signed [EW-1:0] xs, ys, ws, wp7, cl, ct, cr, cb;
  logic signed [EW-1:0] skip_s, x1, w1, w2, xend;
  logic                 x_lt, row_ok, live;
  logic [31:0]          prod;
  logic [SUMW-1:0]      sum;

  always_comb begin
    xs  = EW'(span_x);
    ys  = EW'(span_y);
    ws  = EW'(span_width);
    cl  = $signed(EW'(clip_left));
    ct  = $signed(EW'(clip_top));
    cr  = $signed(EW'(clip_right));
    cb  = $signed(EW'(clip_bottom));
    wp7 = ws + EW'(7);

    bytes_left = (ws > 0) ? wp7[COORD_BITS-1:3] : '0;

    x_lt   = xs < cl;
    skip_s = x_lt ? (cl - xs) : '0;
    x1     = x_lt ? cl : xs;
    w1     = ws - skip_s;
    xend   = x1 + w1;
    w2     = (xend > cr) ? (cr - x1) : w1;
    row_ok = (ys >= ct) && (ys < cb);
    live   = row_ok && (w2 > 0);

    prod = ys[15:0] * row_stride;
    sum  = SUMW'(frame_base) + SUMW'(prod) + SUMW'(x1[15:3]);

    skip    = live ? skip_s : '0;
    pixels  = live ? w2 : '0;
    bit_pos = live ? x1[2:0] : '0;
    address = live ? sum[ADDRESS_BITS-1:0] : '0;
  end

endmodule

`default_nettype wire

[hdl/mpr_bit_packer.sv]
`default_nettype none

module mpr_bit_packer #(
  parameter int PW = 19
) (
  input  wire logic [PW-1:0] skip_i,
  input  wire logic [PW-1:0] pix_i,
  input  wire logic [2:0]    bit_pos_i,
  input  wire logic [7:0]    pend_data_i,
  input  wire logic [7:0]    pend_mask_i,
  input  wire logic [7:0]    src_i,
  output logic [PW-1:0]      skip_o,
  output logic [PW-1:0]      pix_o,
  output logic [2:0]         bit_pos_o,
  output logic [7:0]         pend_data_o,
  output logic [7:0]         pend_mask_o,
  output mpr_pkg::mpr_emit_t emit_o
);

  logic [3:0]  s_used, avail, n;
  logic [8:0]  low9;
  logic [7:0]  low, sel;
  logic [15:0] acc_d, acc_m;
  logic [4:0]  tot;
  logic        done, full;

  always_comb begin
    s_used = (skip_i >= PW'(8)) ? 4'd8 : skip_i[3:0];
    avail  = 4'd8 - s_used;
    n      = (pix_i < PW'(avail)) ? pix_i[3:0] : avail;
    skip_o = skip_i - PW'(s_used);
    pix_o  = pix_i - PW'(n);

    low9  = (9'd1 << n) - 9'd1;
    low   = low9[7:0];
    sel   = (src_i >> s_used) & low;
    acc_d = {8'h00, pend_data_i} | ({8'h00, sel} << bit_pos_i);
    acc_m = {8'h00, pend_mask_i} | ({8'h00, low} << bit_pos_i);
    tot   = {2'b00, bit_pos_i} + {1'b0, n};
    done  = (n != 4'd0) && (pix_o == '0);
    full  = tot[3];

    bit_pos_o   = bit_pos_i;
    pend_data_o = pend_data_i;
    pend_mask_o = pend_mask_i;
    emit_o      = '0;
    emit_o.data0 = acc_d[7:0];
    emit_o.mask0 = acc_m[7:0];
    emit_o.data1 = acc_d[15:8];
    emit_o.mask1 = acc_m[15:8];

    if (n != 4'd0) begin
      bit_pos_o = tot[2:0];
      if (full) begin
        emit_o.emit0 = 1'b1;
        emit_o.last0 = done && (tot == 5'd8);
        if (done && (tot != 5'd8)) begin
          emit_o.emit1    = 1'b1;
          emit_o.addr_inc = 2'd2;
          pend_data_o     = '0;
          pend_mask_o     = '0;
        end else begin
          emit_o.addr_inc = 2'd1;
          pend_data_o     = acc_d[15:8];
          pend_mask_o     = acc_m[15:8];
        end
      end else if (done) begin
        emit_o.emit0    = 1'b1;
        emit_o.last0    = 1'b1;
        emit_o.addr_inc = 2'd1;
        pend_data_o     = '0;
        pend_mask_o     = '0;
      end else begin
        pend_data_o = acc_d[7:0];
        pend_mask_o = acc_m[7:0];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/mpr_out_queue.sv]
`default_nettype none

module mpr_out_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push0,
  input  wire logic          push1,
  input  mpr_pkg::mpr_word_t word0,
  input  mpr_pkg::mpr_word_t word1,
  output logic               space_ok,
  mpr_out_if.source          out_ch
);

  mpr_pkg::mpr_word_t mem_r [mpr_pkg::QUEUE_DEPTH];

  logic [mpr_pkg::QUEUE_PTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [mpr_pkg::QUEUE_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                               pop;

  assign space_ok = cnt_r <= mpr_pkg::QUEUE_CNT_BITS'(mpr_pkg::QUEUE_DEPTH - 2);
  assign pop      = out_ch.valid && out_ch.ready;
  assign wr_p1    = wr_r + 1'b1;

  assign out_ch.valid         = cnt_r != '0;
  assign out_ch.write_address = mem_r[rd_r].write_address;
  assign out_ch.write_data    = mem_r[rd_r].write_data;
  assign out_ch.write_mask    = mem_r[rd_r].write_mask;
  assign out_ch.last_write    = mem_r[rd_r].last_write;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push0 && push1) begin
      wr_nxt = wr_r + 2'd2;
    end else if (push0) begin
      wr_nxt = wr_p1;
    end
    if (pop) begin
      rd_nxt = rd_r + 1'b1;
    end
    cnt_nxt = cnt_r + mpr_pkg::QUEUE_CNT_BITS'(push0) + mpr_pkg::QUEUE_CNT_BITS'(push1)
              - mpr_pkg::QUEUE_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_r] <= word0;
    end
    if (push0 && push1) begin
      mem_r[wr_p1] <= word1;
    end
  end

endmodule

`default_nettype wire

[hdl/mono_packed_row_blit.sv]
// Span blitter for a 1bpp framebuffer (bit 0 of a byte is the leftmost pixel).
// A span command is clipped and its start address computed, or a source byte
// shifted and merged with the pending partial byte against the running span
// state, in the cycle the word is taken; one word per cycle is sustained while
// the queue has two or more free entries, else input is held off. A source byte
// yields zero, one or two masked byte writes; they enter a four-entry result
// queue and leave one per cycle while the receiver is ready, in the cycle after
// the byte at the earliest. The user must write clip and address registers
// through the cfg port only while no span is in flight, unenforced by the block.
`default_nettype none

module mono_packed_row_blit #(
  parameter int ADDRESS_BITS = 32,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [mpr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [mpr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  mpr_in_if.sink                                   in_ch,
  mpr_out_if.source                                out_ch
);

  localparam int EW       = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
  localparam int SBL_BITS = COORD_BITS - 3;
  localparam int OW       = (ADDRESS_BITS > 32) ? ADDRESS_BITS : 32;

  logic [15:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r, row_stride_r;
  logic [31:0] frame_base_r;

  logic [SBL_BITS-1:0]     sbl_r, sbl_nxt;
  logic [EW-1:0]           skip_r, skip_nxt, pix_r, pix_nxt;
  logic [2:0]              bpos_r, bpos_nxt;
  logic [7:0]              pdata_r, pdata_nxt, pmask_r, pmask_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;

  logic [SBL_BITS-1:0]     su_bytes;
  logic [EW-1:0]           su_skip, su_pix, pk_skip, pk_pix;
  logic [2:0]              su_bpos, pk_bpos;
  logic [ADDRESS_BITS-1:0] su_addr, addr_p1;
  logic [7:0]              pk_data, pk_mask;
  mpr_pkg::mpr_emit_t      emit;
  mpr_pkg::mpr_word_t      word0, word1;
  logic [OW-1:0]           addr0_x, addr1_x;
  logic                    accept, byte_live, push0, push1, space_ok;

  mpr_span_setup #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .COORD_BITS   (COORD_BITS),
    .EW           (EW),
    .SBL_BITS     (SBL_BITS)
  ) u_setup (
    .span_x      (in_ch.span_x),
    .span_y      (in_ch.span_y),
    .span_width  (in_ch.span_width),
    .clip_left   (clip_left_r),
    .clip_top    (clip_top_r),
    .clip_right  (clip_right_r),
    .clip_bottom (clip_bottom_r),
    .row_stride  (row_stride_r),
    .frame_base  (frame_base_r),
    .bytes_left  (su_bytes),
    .skip        (su_skip),
    .pixels      (su_pix),
    .bit_pos     (su_bpos),
    .address     (su_addr)
  );

  mpr_bit_packer #(
    .PW (EW)
  ) u_packer (
    .skip_i      (skip_r),
    .pix_i       (pix_r),
    .bit_pos_i   (bpos_r),
    .pend_data_i (pdata_r),
    .pend_mask_i (pmask_r),
    .src_i       (in_ch.source_byte),
    .skip_o      (pk_skip),
    .pix_o       (pk_pix),
    .bit_pos_o   (pk_bpos),
    .pend_data_o (pk_data),
    .pend_mask_o (pk_mask),
    .emit_o      (emit)
  );

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && in_ch.ready;
  assign byte_live   = accept && in_ch.req_type && (sbl_r != '0);
  assign push0       = byte_live && emit.emit0;
  assign push1       = byte_live && emit.emit1;
  assign addr_p1     = addr_r + 1'b1;
  assign addr0_x     = OW'(addr_r);
  assign addr1_x     = OW'(addr_p1);

  always_comb begin
    word0.write_address = addr0_x[31:0];
    word0.write_data    = emit.data0;
    word0.write_mask    = emit.mask0;
    word0.last_write    = emit.last0;
    word1.write_address = addr1_x[31:0];
    word1.write_data    = emit.data1;
    word1.write_mask    = emit.mask1;
    word1.last_write    = 1'b1;
  end

  always_comb begin
    sbl_nxt   = sbl_r;
    skip_nxt  = skip_r;
    pix_nxt   = pix_r;
    bpos_nxt  = bpos_r;
    pdata_nxt = pdata_r;
    pmask_nxt = pmask_r;
    addr_nxt  = addr_r;
    if (accept && !in_ch.req_type) begin
      sbl_nxt   = su_bytes;
      skip_nxt  = su_skip;
      pix_nxt   = su_pix;
      bpos_nxt  = su_bpos;
      pdata_nxt = '0;
      pmask_nxt = '0;
      addr_nxt  = su_addr;
    end else if (byte_live) begin
      sbl_nxt   = sbl_r - 1'b1;
      skip_nxt  = pk_skip;
      pix_nxt   = pk_pix;
      bpos_nxt  = pk_bpos;
      pdata_nxt = pk_data;
      pmask_nxt = pk_mask;
      addr_nxt  = addr_r + ADDRESS_BITS'(emit.addr_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbl_r   <= '0;
      skip_r  <= '0;
      pix_r   <= '0;
      bpos_r  <= '0;
      pdata_r <= '0;
      pmask_r <= '0;
      addr_r  <= '0;
    end else begin
      sbl_r   <= sbl_nxt;
      skip_r  <= skip_nxt;
      pix_r   <= pix_nxt;
      bpos_r  <= bpos_nxt;
      pdata_r <= pdata_nxt;
      pmask_r <= pmask_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= mpr_pkg::CLIP_MAX;
      clip_bottom_r <= mpr_pkg::CLIP_MAX;
      row_stride_r  <= '0;
      frame_base_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mpr_pkg::CFG_CLIP_LEFT:   clip_left_r   <= cfg_wdata[15:0];
        mpr_pkg::CFG_CLIP_TOP:    clip_top_r    <= cfg_wdata[15:0];
        mpr_pkg::CFG_CLIP_RIGHT:  clip_right_r  <= cfg_wdata[15:0];
        mpr_pkg::CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_wdata[15:0];
        mpr_pkg::CFG_ROW_STRIDE:  row_stride_r  <= cfg_wdata[15:0];
        mpr_pkg::CFG_FRAME_BASE:  frame_base_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  mpr_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push0    (push0),
    .push1    (push1),
    .word0    (word0),
    .word1    (word1),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[hdl/mpr_checker.sv]
`default_nettype none

module mpr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_address,
  input wire logic [7:0]  out_data,
  input wire logic [7:0]  out_mask,
  input wire logic        out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_address) && $stable(out_data)
      && $stable(out_mask) && $stable(out_last))
    else $error("stalled write word changed");

  a_data_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data & ~out_mask) == 8'h00)
    else $error("data bits outside mask");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mask != 8'h00)
    else $error("write with empty mask");

  // a non-final write of a span is always a completed byte at the top end
  a_inner_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_mask[7])
    else $error("partial write not marked last");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind mono_packed_row_blit mpr_checker u_mpr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_address (out_ch.write_address),
  .out_data    (out_ch.write_data),
  .out_mask    (out_ch.write_mask),
  .out_last    (out_ch.last_write)
);

`default_nettype wire

[sim/mono_packed_row_blit_tb.sv]
`default_nettype none

module mono_packed_row_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_SPAN = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  localparam int RX_ALWAYS   = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_SPARSE   = 2;
  localparam int RX_PERIODIC = 3;

  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 150;
  localparam int N_PHASES     = 10;
  localparam int DIR_N        = 27;

  typedef struct packed {
    logic        req_type;
    logic [15:0] span_x;
    logic [15:0] span_y;
    logic [15:0] span_width;
    logic [7:0]  source_byte;
  } blit_req_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [15:0]        w;
    logic [7:0]         sbyte;
    logic               typed;  // expected writes given below, not predicted
    logic               t_one;  // typed: one write, else none
    mpr_pkg::mpr_word_t t_wr;
  } dir_row_t;

  localparam mpr_pkg::mpr_word_t NO_WR = '0;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'h5A, 1'b1, 1'b0, NO_WR},
    '{REQ_SPAN, 16'd0, 16'd0, 16'd8, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hA5, 1'b1, 1'b1, '{32'h0, 8'hA5, 8'hFF, 1'b1}},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'h3C, 1'b1, 1'b0, NO_WR},
    '{REQ_SPAN, 16'd8, 16'd0, 16'd1, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b1, 1'b1, '{32'h1, 8'h01, 8'h01, 1'b1}},
    '{REQ_SPAN, 16'd3, 16'd0, 16'd8, 8'h00, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b0, 1'b0, NO_WR},
    '{REQ_SPAN, 16'hFFFB, 16'd0, 16'd10, 8'h00, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'h03, 1'b0, 1'b0, NO_WR},
    '{REQ_SPAN, 16'd0, 16'hFFFF, 16'd16, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b1, 1'b0, NO_WR},
    '{REQ_SPAN, 16'd0, 16'd0, 16'd0, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b1, 1'b0, NO_WR},
    '{REQ_SPAN, 16'd0, 16'd0, 16'h8000, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_SPAN, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h00, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'h81, 1'b0, 1'b0, NO_WR},
    '{REQ_SPAN, 16'h8000, 16'h8000, 16'h7FFF, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_SPAN, 16'h8000, 16'd0, 16'h7FFF, 8'h00, 1'b1, 1'b0, NO_WR},
    '{REQ_SPAN, 16'd1, 16'd2, 16'd16, 8'h00, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'h7E, 1'b0, 1'b0, NO_WR},
    '{REQ_SPAN, 16'd4, 16'd0, 16'd12, 8'h00, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'hC3, 1'b0, 1'b0, NO_WR},
    '{REQ_BYTE, 16'd0, 16'd0, 16'd0, 8'h0F, 1'b0, 1'b0, NO_WR}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mpr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [mpr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  mpr_in_if #(.COORD_BITS(16)) in_ch ();
  mpr_out_if out_ch ();

  mono_packed_row_blit #(
    .ADDRESS_BITS(32),
    .COORD_BITS(16)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // clip and address registers as the block holds them
  logic [15:0] clip_l, clip_t, clip_r, clip_b, row_pitch;
  logic [31:0] fb_base;

  // running span state
  logic [12:0] bytes_left;
  logic [16:0] skip_left;
  logic [16:0] pix_left;
  logic [31:0] dst_addr;
  logic [2:0]  dst_bpos;
  logic [7:0]  pend_data;
  logic [7:0]  pend_mask;

  mpr_pkg::mpr_word_t writes_due [$];
  mpr_pkg::mpr_word_t new_writes [$];
  logic               word_used;

  int  err_cnt   = 0;
  int  write_cnt = 0;
  int  word_cnt  = 0;
  int  used_cnt  = 0;
  int  span_cnt  = 0;
  int  burst_left = 0;
  logic tx_gaps = 1'b0;
  logic hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // span clipping and byte realignment; fills new_writes with the writes one word causes
  task automatic blit_predict(input blit_req_t rq);
    longint x, y, w, skip;
    int k;
    logic [3:0] bpos;
    mpr_pkg::mpr_word_t wr;
    new_writes.delete();
    word_used = 1'b1;
    if (rq.req_type == REQ_SPAN) begin
      x = longint'($signed(rq.span_x));
      y = longint'($signed(rq.span_y));
      w = longint'($signed(rq.span_width));
      skip = 0;
      bytes_left = (w > 0) ? 13'((w + 7) >>> 3) : 13'd0;
      skip_left = '0;
      pix_left  = '0;
      dst_bpos  = '0;
      pend_data = '0;
      pend_mask = '0;
      dst_addr  = '0;
      if (y < longint'(clip_t) || y >= longint'(clip_b)) return;
      if (x < longint'(clip_l)) begin
        skip = longint'(clip_l) - x;
        x = x + skip;
        w = w - skip;
      end
      if (x + w > longint'(clip_r)) w = longint'(clip_r) - x;
      if (w <= 0) return;
      skip_left = 17'(skip);
      pix_left  = 17'(w);
      dst_bpos  = 3'(x);
      dst_addr  = 32'(longint'(fb_base) + y * longint'(row_pitch) + (x >>> 3));
    end else if (bytes_left == 0) begin
      word_used = 1'b0;
    end else begin
      bytes_left = bytes_left - 1'b1;
      bpos = {1'b0, dst_bpos};
      for (k = 0; k < 8; k++) begin
        if (skip_left != 0) begin
          skip_left = skip_left - 1'b1;
          continue;
        end
        if (pix_left == 0) break;
        pend_data[bpos[2:0]] = rq.source_byte[k];
        pend_mask[bpos[2:0]] = 1'b1;
        bpos = bpos + 1'b1;
        pix_left = pix_left - 1'b1;
        if (bpos == 4'd8 || pix_left == 0) begin
          wr.write_address = dst_addr;
          wr.write_data    = pend_data;
          wr.write_mask    = pend_mask;
          wr.last_write    = (pix_left == 0);
          new_writes.push_back(wr);
          dst_addr  = dst_addr + 1'b1;
          pend_data = '0;
          pend_mask = '0;
          bpos = bpos & 4'd7;
        end
      end
      dst_bpos = bpos[2:0];
    end
  endtask

  // called at a rising edge; returns at the edge of acceptance or after the gap that follows
  task automatic send_req(input blit_req_t rq, input logic typed, input logic t_one,
                          input mpr_pkg::mpr_word_t t_wr);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rq.req_type;
    in_ch.span_x      <= rq.span_x;
    in_ch.span_y      <= rq.span_y;
    in_ch.span_width  <= rq.span_width;
    in_ch.source_byte <= rq.source_byte;
    do @(posedge clk); while (!in_ch.ready);
    blit_predict(rq);
    if (typed) begin
      if (t_one) writes_due.push_back(t_wr);
    end else begin
      foreach (new_writes[i]) writes_due.push_back(new_writes[i]);
    end
    word_cnt++;
    if (word_used) used_cnt++;
    gap = 0;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 7);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_span_cmd(input int x, input int y, input int w);
    blit_req_t rq;
    rq.req_type    = REQ_SPAN;
    rq.span_x      = 16'(x);
    rq.span_y      = 16'(y);
    rq.span_width  = 16'(w);
    rq.source_byte = 8'($urandom());
    send_req(rq, 1'b0, 1'b0, NO_WR);
    span_cnt++;
  endtask

  task automatic send_src_byte();
    blit_req_t rq;
    rq.req_type    = REQ_BYTE;
    rq.span_x      = 16'($urandom());
    rq.span_y      = 16'($urandom());
    rq.span_width  = 16'($urandom());
    rq.source_byte = 8'($urandom());
    send_req(rq, 1'b0, 1'b0, NO_WR);
  endtask

  task automatic wait_drained();
    while (writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // junk: fill the unused upper bits of the 16-bit registers' write data
  task automatic cfg_load(input logic [15:0] cl, input logic [15:0] ct, input logic [15:0] cr,
                          input logic [15:0] cb, input logic [15:0] rs, input logic [31:0] fb,
                          input logic junk);
    logic [mpr_pkg::CFG_INDEX_BITS-1:0] idx [6];
    logic [mpr_pkg::CFG_DATA_BITS-1:0]  val [6];
    logic [15:0] hi;
    int j;
    hi = junk ? 16'($urandom()) : 16'd0;
    idx[0] = mpr_pkg::CFG_CLIP_LEFT;   val[0] = {hi, cl};
    idx[1] = mpr_pkg::CFG_CLIP_TOP;    val[1] = {hi, ct};
    idx[2] = mpr_pkg::CFG_CLIP_RIGHT;  val[2] = {hi, cr};
    idx[3] = mpr_pkg::CFG_CLIP_BOTTOM; val[3] = {hi, cb};
    idx[4] = mpr_pkg::CFG_ROW_STRIDE;  val[4] = {hi, rs};
    idx[5] = mpr_pkg::CFG_FRAME_BASE;  val[5] = fb;
    for (j = 0; j < 6; j++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[j];
      cfg_wdata <= val[j];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    clip_l    = cl;
    clip_t    = ct;
    clip_r    = cr;
    clip_b    = cb;
    row_pitch = rs;
    fb_base   = fb;
  endtask

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin : rx_side
    int mode, left, hold_cnt;
    out_ch.ready = 1'b0;
    mode = RX_ALWAYS;
    left = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= (left % 5) != 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : write_check
    mpr_pkg::mpr_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (writes_due.size() == 0) begin
        $display("%0t: unexpected write: expected none, got addr %h data %h mask %h last %b",
                 $time, out_ch.write_address, out_ch.write_data, out_ch.write_mask,
                 out_ch.last_write);
        err_cnt++;
      end else begin
        want = writes_due.pop_front();
        write_cnt++;
        if (out_ch.write_address !== want.write_address) begin
          $display("%0t: write_address expected %h got %h", $time, want.write_address,
                   out_ch.write_address);
          err_cnt++;
        end
        if (out_ch.write_data !== want.write_data) begin
          $display("%0t: write_data expected %h got %h", $time, want.write_data,
                   out_ch.write_data);
          err_cnt++;
        end
        if (out_ch.write_mask !== want.write_mask) begin
          $display("%0t: write_mask expected %h got %h", $time, want.write_mask,
                   out_ch.write_mask);
          err_cnt++;
        end
        if (out_ch.last_write !== want.last_write) begin
          $display("%0t: last_write expected %b got %b", $time, want.last_write,
                   out_ch.last_write);
          err_cnt++;
        end
      end
    end
  end

  initial begin : run_limit
    #5000000;
    $display("FAIL mono_packed_row_blit");
    $finish;
  end

  initial begin : main_seq
    blit_req_t rq;
    int p, i, x, y, w, nb, r, wx, wy, phase_goal;
    logic held, paused;
    logic [15:0] cl, ct;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_SPAN;
    in_ch.span_x      = '0;
    in_ch.span_y      = '0;
    in_ch.span_width  = '0;
    in_ch.source_byte = '0;

    clip_l = 16'd0;
    clip_t = 16'd0;
    clip_r = mpr_pkg::CLIP_MAX;
    clip_b = mpr_pkg::CLIP_MAX;
    row_pitch = 16'd0;
    fb_base = 32'd0;
    bytes_left = '0;
    skip_left = '0;
    pix_left = '0;
    dst_addr = '0;
    dst_bpos = '0;
    pend_data = '0;
    pend_mask = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    tx_gaps = 1'b1;
    for (i = 0; i < DIR_N; i++) begin
      rq = '{DIR_TAB[i].kind, DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].w, DIR_TAB[i].sbyte};
      send_req(rq, DIR_TAB[i].typed, DIR_TAB[i].t_one, DIR_TAB[i].t_wr);
    end

    for (p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        case (p)
          1: cfg_load(16'd5, 16'd3, 16'd77, 16'd9, 16'd20, 32'h0000_1000, 1'b0);
          3: cfg_load(16'd0, 16'd0, mpr_pkg::CLIP_MAX, mpr_pkg::CLIP_MAX, 16'hFFFF,
                      32'hFFFF_FFF0, 1'b0);
          4: cfg_load(mpr_pkg::CLIP_MAX, mpr_pkg::CLIP_MAX, 16'd0, 16'd0, 16'd0,
                      32'hFFFF_FFFF, 1'b0);
          default: begin
            cl = 16'($urandom_range(0, 200));
            ct = 16'($urandom_range(0, 50));
            cfg_load(cl, ct, cl + 16'($urandom_range(0, 150)), ct + 16'($urandom_range(0, 12)),
                     16'($urandom()), $urandom(), 1'b1);
          end
        endcase
      end
      tx_gaps = (p % 2 == 0);
      held = 1'b0;
      paused = 1'b0;
      wx = (clip_l > 16'd32700) ? 32700 : int'(clip_l);
      wy = (clip_t > 16'd32700) ? 32700 : int'(clip_t);
      phase_goal = used_cnt + ((p == 4) ? 40 : 118);
      while (used_cnt < phase_goal) begin
        if ((p == 1 || p == 6) && !held && used_cnt + 90 < phase_goal) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (p == 2 && !paused && used_cnt + 60 < phase_goal) begin
          in_ch.valid <= 1'b0;
          while (writes_due.size() != 0) @(posedge clk);
          @(posedge clk);
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
          x = wx + $urandom_range(0, 48) - 24;
          y = ($urandom_range(0, 7) == 0) ? 32767 - $urandom_range(0, 4)
                                          : wy + $urandom_range(0, 14) - 2;
          r = $urandom_range(0, 99);
          if (r < 4) w = -int'($urandom_range(0, 40));
          else if (r < 10) w = $urandom_range(41, 400);
          else w = $urandom_range(1, 40);
          nb = (w > 0) ? (w + 7) / 8 : 0;
          r = $urandom_range(0, 99);
          if (r < 10 && nb > 0) nb = $urandom_range(0, nb - 1);
          else if (r < 20) nb = nb + $urandom_range(1, 3);
          send_span_cmd(x, y, w);
          repeat (nb) send_src_byte();
        end else if (r < 90) begin
          send_span_cmd(int'($urandom()), int'($urandom()), int'($urandom()));
          repeat ($urandom_range(0, 3)) send_src_byte();
        end else begin
          repeat ($urandom_range(1, 3)) send_src_byte();
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();

    $display("Covered %0d input words (%0d span commands), %0d writes checked", word_cnt,
             span_cnt, write_cnt);
    $display("over %0d clip and address settings, with sender gaps and receiver stalls",
             N_PHASES);
    if (err_cnt == 0 && writes_due.size() == 0) begin
      $display("PASS mono_packed_row_blit");
    end else begin
      $display("FAIL mono_packed_row_blit");
    end
    $finish;
  end

endmodule

`default_nettype wire
